// ===== rtl/srio_pkg.sv =====
// ----------------------------------------------------------------------------
// srio_pkg
// Shared types, codes and defaults for the shift register I/O chain scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package srio_pkg;

  localparam int MAX_SR_DEF     = 16;
  localparam int DOUT_PAGES_DEF = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [7:0] PASSIVE_IN = 8'hff;

  localparam logic [2:0] OPC_WRITE_OUT      = 3'd0;
  localparam logic [2:0] OPC_SCAN_START     = 3'd1;
  localparam logic [2:0] OPC_SHIFT          = 3'd2;
  localparam logic [2:0] OPC_DEBOUNCE_START = 3'd3;
  localparam logic [2:0] OPC_READ_IN        = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_BUSY     = 2'd2;
  localparam logic [1:0] ST_NO_SCAN  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_RELOAD = 2'd1;

  typedef enum logic [2:0] {
    OP_WRITE_OUT,
    OP_SCAN_START,
    OP_SHIFT,
    OP_DEBOUNCE_START,
    OP_READ_IN,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       idx_ok;
    logic       page_ok;
    logic [3:0] sr_index;
    logic [1:0] page_select;
    logic [7:0] byte_value;
    logic       clear_changed;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] dout_byte;
    logic [7:0] din_value;
    logic [7:0] changed_value;
    logic [1:0] active_page;
    logic       scan_complete;
    logic       latch_pulse;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/srio_front.sv =====
// ----------------------------------------------------------------------------
// srio_front
// Accepts input items, decodes the opcode and checks index ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module srio_front #(
  parameter int MAX_SR     = srio_pkg::MAX_SR_DEF,
  parameter int DOUT_PAGES = srio_pkg::DOUT_PAGES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    opcode,
  input  wire logic [3:0]    sr_index,
  input  wire logic [1:0]    page_select,
  input  wire logic [7:0]    byte_value,
  input  wire logic          clear_changed,
  input  wire logic          q_full,
  input  wire logic          clearing,
  output logic               push,
  output srio_pkg::cmd_t     push_cmd
);

  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= q_full || clearing;
    end
  end

  assign in_stall = busy || q_full || clearing;
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_cmd               = '0;
    push_cmd.idx_ok        = 32'(sr_index) < 32'(MAX_SR);
    push_cmd.page_ok       = 32'(page_select) < 32'(DOUT_PAGES);
    push_cmd.sr_index      = sr_index;
    push_cmd.page_select   = page_select;
    push_cmd.byte_value    = byte_value;
    push_cmd.clear_changed = clear_changed;
    unique case (opcode)
      srio_pkg::OPC_WRITE_OUT:      push_cmd.op = srio_pkg::OP_WRITE_OUT;
      srio_pkg::OPC_SCAN_START:     push_cmd.op = srio_pkg::OP_SCAN_START;
      srio_pkg::OPC_SHIFT:          push_cmd.op = srio_pkg::OP_SHIFT;
      srio_pkg::OPC_DEBOUNCE_START: push_cmd.op = srio_pkg::OP_DEBOUNCE_START;
      srio_pkg::OPC_READ_IN:        push_cmd.op = srio_pkg::OP_READ_IN;
      default:                      push_cmd.op = srio_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/srio_queue.sv =====
// ----------------------------------------------------------------------------
// srio_queue
// Short command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
`default_nettype none

module srio_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  srio_pkg::cmd_t      push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output srio_pkg::cmd_t      head_cmd
);

  localparam int PTR_W = (srio_pkg::QUEUE_DEPTH > 1) ? $clog2(srio_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(srio_pkg::QUEUE_DEPTH + 1);

  srio_pkg::cmd_t   entries [srio_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(srio_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(srio_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(srio_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srio_back.sv =====
// ----------------------------------------------------------------------------
// srio_back
// Executes queued commands against the page store and input buffers, runs
// the per-register completion sweep and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srio_back #(
  parameter int MAX_SR     = srio_pkg::MAX_SR_DEF,
  parameter int DOUT_PAGES = srio_pkg::DOUT_PAGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  input  srio_pkg::cmd_t                       q_cmd,
  output logic                                 q_pop,
  output logic                                 clearing,
  input  wire logic                            cfg_we,
  input  wire logic [srio_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srio_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output srio_pkg::res_t                       out_res
);

  localparam int SR_W     = (MAX_SR > 1) ? $clog2(MAX_SR) : 1;
  localparam int PG_W     = (DOUT_PAGES > 1) ? $clog2(DOUT_PAGES) : 1;
  localparam int CNT_W    = ($clog2(MAX_SR + 1) > 5) ? $clog2(MAX_SR + 1) : 5;
  localparam int IX_W     = (SR_W > 4) ? SR_W : 4;
  localparam int PX_W     = (PG_W > 2) ? PG_W : 2;
  localparam int DO_W     = PG_W + SR_W;
  localparam int DO_DEPTH = 1 << DO_W;
  localparam int SR_DEPTH = 1 << SR_W;

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_SHIFT_RD = 6'b000100,
    S_SWEEP    = 6'b001000,
    S_READ_RD  = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t           state;
  logic [DO_W-1:0]  clr_idx;
  logic [CNT_W-1:0] active_count;
  logic [15:0]      deb_reload;
  logic [15:0]      deb_count;
  logic             xfer_idle;
  logic [CNT_W-1:0] shift_pos;
  logic [PG_W-1:0]  page_cnt;
  logic [CNT_W-1:0] sweep_rd;
  logic             sweep_wr_pend;
  logic [SR_W-1:0]  sweep_wr_idx;
  logic             sweep_deb;
  srio_pkg::cmd_t   cmd;
  srio_pkg::res_t   hold;

  logic [7:0] dout_mem [DO_DEPTH];
  logic [7:0] comm_mem [SR_DEPTH];
  logic [7:0] inc_mem  [SR_DEPTH];
  logic [7:0] flag_mem [SR_DEPTH];
  logic [7:0] dout_rd;
  logic [7:0] comm_rd;
  logic [7:0] inc_rd;
  logic [7:0] flag_rd;

  logic [IX_W-1:0]  q_sr_ext;
  logic [IX_W-1:0]  c_sr_ext;
  logic [PX_W-1:0]  q_pg_ext;
  logic [PX_W-1:0]  page_ext;
  logic [SR_W-1:0]  q_sr_addr;
  logic [SR_W-1:0]  c_sr_addr;
  logic [SR_W-1:0]  pos_addr;
  logic             pos_ok;
  logic [CNT_W-1:0] pos_next;
  logic [PG_W:0]    page_inc;
  logic [DO_W-1:0]  dout_raddr;
  logic [SR_W-1:0]  din_raddr;
  logic             res_free;
  logic [7:0]       flag_new;
  logic [CNT_W-1:0] cfg_count;

  logic             dout_we;
  logic [DO_W-1:0]  dout_waddr;
  logic [7:0]       dout_wdata;
  logic             inc_we;
  logic [SR_W-1:0]  inc_waddr;
  logic [7:0]       inc_wdata;
  logic             comm_we;
  logic [SR_W-1:0]  comm_waddr;
  logic [7:0]       comm_wdata;
  logic             flag_we;
  logic [SR_W-1:0]  flag_waddr;
  logic [7:0]       flag_wdata;

  assign q_sr_ext   = IX_W'(q_cmd.sr_index);
  assign c_sr_ext   = IX_W'(cmd.sr_index);
  assign q_pg_ext   = PX_W'(q_cmd.page_select);
  assign page_ext   = PX_W'(page_cnt);
  assign q_sr_addr  = q_sr_ext[SR_W-1:0];
  assign c_sr_addr  = c_sr_ext[SR_W-1:0];
  assign pos_addr   = shift_pos[SR_W-1:0];
  assign pos_ok     = shift_pos < CNT_W'(MAX_SR);
  assign pos_next   = shift_pos + 1'b1;
  assign page_inc   = {1'b0, page_cnt} + 1'b1;
  assign dout_raddr = {page_cnt, pos_addr};
  assign din_raddr  = (state == S_SWEEP) ? sweep_rd[SR_W-1:0] : q_sr_addr;
  assign res_free   = !out_valid || !out_stall;
  assign q_pop      = (state == S_IDLE) && q_valid;
  assign clearing   = state == S_CLEAR;
  assign flag_new   = flag_rd | (comm_rd ^ inc_rd);
  assign cfg_count  = CNT_W'(cfg_data[4:0]);

  always_comb begin
    dout_we    = 1'b0;
    dout_waddr = {q_pg_ext[PG_W-1:0], q_sr_addr};
    dout_wdata = q_cmd.byte_value;
    if (state == S_CLEAR) begin
      dout_we    = 1'b1;
      dout_waddr = clr_idx;
      dout_wdata = '0;
    end else if (q_pop && q_cmd.op == srio_pkg::OP_WRITE_OUT && q_cmd.idx_ok
                 && q_cmd.page_ok) begin
      dout_we = 1'b1;
    end
  end

  always_comb begin
    inc_we    = 1'b0;
    inc_waddr = pos_addr;
    inc_wdata = q_cmd.byte_value;
    if (state == S_CLEAR) begin
      inc_we    = 1'b1;
      inc_waddr = clr_idx[SR_W-1:0];
      inc_wdata = srio_pkg::PASSIVE_IN;
    end else if (q_pop && q_cmd.op == srio_pkg::OP_SHIFT && !xfer_idle && pos_ok) begin
      inc_we = 1'b1;
    end
  end

  always_comb begin
    comm_we    = 1'b0;
    comm_waddr = sweep_wr_idx;
    comm_wdata = sweep_deb ? (inc_rd ^ flag_new) : inc_rd;
    flag_we    = 1'b0;
    flag_waddr = sweep_wr_idx;
    flag_wdata = sweep_deb ? 8'h00 : flag_new;
    if (state == S_CLEAR) begin
      comm_we    = 1'b1;
      comm_waddr = clr_idx[SR_W-1:0];
      comm_wdata = srio_pkg::PASSIVE_IN;
      flag_we    = 1'b1;
      flag_waddr = clr_idx[SR_W-1:0];
      flag_wdata = 8'h00;
    end else if (state == S_SWEEP && sweep_wr_pend) begin
      comm_we = 1'b1;
      flag_we = 1'b1;
    end else if (state == S_READ_RD && cmd.idx_ok && cmd.clear_changed) begin
      flag_we    = 1'b1;
      flag_waddr = c_sr_addr;
      flag_wdata = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (dout_we) begin
      dout_mem[dout_waddr] <= dout_wdata;
    end
    dout_rd <= dout_mem[dout_raddr];
  end

  always_ff @(posedge clk) begin
    if (inc_we) begin
      inc_mem[inc_waddr] <= inc_wdata;
    end
    inc_rd <= inc_mem[din_raddr];
  end

  always_ff @(posedge clk) begin
    if (comm_we) begin
      comm_mem[comm_waddr] <= comm_wdata;
    end
    comm_rd <= comm_mem[din_raddr];
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rd <= flag_mem[din_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      active_count  <= CNT_W'(MAX_SR);
      deb_reload    <= '0;
      deb_count     <= '0;
      xfer_idle     <= 1'b1;
      shift_pos     <= '0;
      page_cnt      <= '0;
      sweep_rd      <= '0;
      sweep_wr_pend <= 1'b0;
      sweep_deb     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (&clr_idx) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_cmd.op)
              srio_pkg::OP_SCAN_START: begin
                state <= S_DONE;
                if (active_count != '0 && xfer_idle) begin
                  xfer_idle <= 1'b0;
                  shift_pos <= '0;
                  page_cnt  <= (page_inc >= (PG_W + 1)'(DOUT_PAGES)) ? '0
                                                                    : page_inc[PG_W-1:0];
                end
              end
              srio_pkg::OP_SHIFT: begin
                state <= xfer_idle ? S_DONE : S_SHIFT_RD;
              end
              srio_pkg::OP_DEBOUNCE_START: begin
                deb_count <= deb_reload;
                state     <= S_DONE;
              end
              srio_pkg::OP_READ_IN: begin
                state <= S_READ_RD;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SHIFT_RD: begin
          shift_pos <= pos_next;
          if (pos_next >= active_count) begin
            xfer_idle     <= 1'b1;
            sweep_rd      <= '0;
            sweep_wr_pend <= 1'b0;
            sweep_deb     <= deb_reload != '0 && deb_count != '0;
            if (deb_reload != '0 && deb_count != '0) begin
              deb_count <= deb_count - 1'b1;
            end
            state <= S_SWEEP;
          end else begin
            state <= S_DONE;
          end
        end
        S_SWEEP: begin
          if (sweep_rd < active_count) begin
            sweep_rd      <= sweep_rd + 1'b1;
            sweep_wr_pend <= 1'b1;
          end else begin
            sweep_wr_pend <= 1'b0;
            if (!sweep_wr_pend) begin
              state <= S_DONE;
            end
          end
        end
        S_READ_RD: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        if (cfg_index == srio_pkg::CFG_ACTIVE_SR_COUNT) begin
          active_count <= (cfg_count > CNT_W'(MAX_SR)) ? CNT_W'(MAX_SR) : cfg_count;
        end else if (cfg_index == srio_pkg::CFG_DEBOUNCE_RELOAD) begin
          deb_reload <= cfg_data;
          if (deb_count > cfg_data) begin
            deb_count <= cfg_data;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SWEEP && sweep_rd < active_count) begin
      sweep_wr_idx <= sweep_rd[SR_W-1:0];
    end
    if (q_pop) begin
      cmd  <= q_cmd;
      hold <= '0;
      unique case (q_cmd.op)
        srio_pkg::OP_SCAN_START: begin
          if (active_count == '0) begin
            hold.status <= srio_pkg::ST_DISABLED;
          end else if (!xfer_idle) begin
            hold.status <= srio_pkg::ST_BUSY;
          end else begin
            hold.latch_pulse <= 1'b1;
          end
        end
        srio_pkg::OP_SHIFT: begin
          if (xfer_idle) begin
            hold.status <= srio_pkg::ST_NO_SCAN;
          end
        end
        default: begin
        end
      endcase
    end
    if (state == S_SHIFT_RD) begin
      hold.dout_byte <= pos_ok ? dout_rd : 8'h00;
      if (pos_next >= active_count) begin
        hold.scan_complete <= 1'b1;
        hold.latch_pulse   <= 1'b1;
      end
    end
    if (state == S_READ_RD) begin
      hold.din_value     <= cmd.idx_ok ? comm_rd : srio_pkg::PASSIVE_IN;
      hold.changed_value <= cmd.idx_ok ? flag_rd : 8'h00;
    end
    if (state == S_DONE && res_free) begin
      out_res             <= hold;
      out_res.active_page <= page_ext[1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/shift_register_io_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// shift_register_io_scanner_unit
// Scans output and input shift register chains with paged outputs, sticky
// change flags and input debouncing.
// ----------------------------------------------------------------------------
// Each item passes from transfer through the queue and the execute step to the
// result register; a shifted byte or an input read adds a read step, and a
// completing byte adds the sweep over the active registers, one entry per cycle
// through the buffers. The queue takes up to two items while the back is busy.
// After reset a clearing pass over every store entry fills the stores, with
// in_stall high; config is taken as ever.
`default_nettype none

module shift_register_io_scanner_unit #(
  parameter int MAX_SR     = srio_pkg::MAX_SR_DEF,
  parameter int DOUT_PAGES = srio_pkg::DOUT_PAGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [2:0]                      opcode,
  input  wire logic [3:0]                      sr_index,
  input  wire logic [1:0]                      page_select,
  input  wire logic [7:0]                      byte_value,
  input  wire logic                            clear_changed,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           status,
  output logic [7:0]                           dout_byte,
  output logic [7:0]                           din_value,
  output logic [7:0]                           changed_value,
  output logic [1:0]                           active_page,
  output logic                                 scan_complete,
  output logic                                 latch_pulse,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [srio_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srio_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           push;
  srio_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  srio_pkg::cmd_t q_cmd;
  logic           clearing;
  srio_pkg::res_t out_res;

  assign cfg_ready = 1'b1;

  srio_front #(
    .MAX_SR     (MAX_SR),
    .DOUT_PAGES (DOUT_PAGES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .sr_index      (sr_index),
    .page_select   (page_select),
    .byte_value    (byte_value),
    .clear_changed (clear_changed),
    .q_full        (q_full),
    .clearing      (clearing),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  srio_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  srio_back #(
    .MAX_SR     (MAX_SR),
    .DOUT_PAGES (DOUT_PAGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign status        = out_res.status;
  assign dout_byte     = out_res.dout_byte;
  assign din_value     = out_res.din_value;
  assign changed_value = out_res.changed_value;
  assign active_page   = out_res.active_page;
  assign scan_complete = out_res.scan_complete;
  assign latch_pulse   = out_res.latch_pulse;

  assert property (@(posedge clk) disable iff (rst)
    out_valid && scan_complete |-> latch_pulse && status == srio_pkg::ST_OK)
    else $error("Scan completion without latch pulse or with error status.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != srio_pkg::ST_OK |->
      dout_byte == 8'h00 && !latch_pulse && !scan_complete && changed_value == 8'h00)
    else $error("Refused item carries result data.");

  assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall && !q_valid)
    else $error("Input transfer possible during the clearing pass.");

  assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("Result or input channel active right after reset.");

endmodule

`default_nettype wire
